// File: hw/rtl/minimum_spanning_forest_core_macros.svh
// Assertion macros for the minimum spanning forest core.
// Used by the checker module; depends on a clock named clk and a reset named rst_n.
`ifndef MINIMUM_SPANNING_FOREST_CORE_MACROS_SVH
`define MINIMUM_SPANNING_FOREST_CORE_MACROS_SVH
// The consequent must hold in the same cycle as the antecedent.
`define MSF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define MSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hw/rtl/msf_pkg.sv
// Shared types and constants of the minimum spanning forest core.
// No dependencies.
package msf_pkg;

  localparam int TreeMax = 63;

  typedef struct packed {
    logic [5:0]         head_node;
    logic [5:0]         tail_node;
    logic signed [31:0] edge_cost;
    logic signed [15:0] edge_ident;
    logic               final_edge;
  } in_t;

  typedef struct packed {
    logic [14:0] tree_edge_id;
    logic        is_summary;
    logic [5:0]  tree_edge_count;
    logic        store_overflow;
    logic        run_end;
  } out_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLEAR = 9'b000000010,
    S_SCAN  = 9'b000000100,
    S_RD_H  = 9'b000001000,
    S_CHK_H = 9'b000010000,
    S_RD_T  = 9'b000100000,
    S_CHK_T = 9'b001000000,
    S_LINK  = 9'b010000000,
    S_SUMM  = 9'b100000000
  } state_t;

  typedef struct packed {
    logic load;
    logic job_init;
    logic clr;
    logic scan_init;
    logic scan;
    logic find_h_init;
    logic find_t_init;
    logic walk_rd;
    logic walk_chk;
    logic save_h;
    logic link;
    logic summary;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic n_zero;
    logic scan_done;
    logic root_hit;
    logic last_pass;
  } sts_t;

endpackage

// File: hw/rtl/msf_ctrl.sv
// Sequencing state machine of the minimum spanning forest core.
// Depends on msf_pkg; drives the datapath by command and reads its status.
module msf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_final,
  input  msf_pkg::sts_t sts,
  output msf_pkg::cmd_t cmd,
  output logic          busy
);
  import msf_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_final) begin
            cmd.job_init = 1'b1;
            state_nxt = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          cmd.scan_init = 1'b1;
          state_nxt = sts.n_zero ? S_SUMM : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          cmd.find_h_init = 1'b1;
          state_nxt = S_RD_H;
        end
      end
      S_RD_H: begin
        cmd.walk_rd = 1'b1;
        state_nxt = S_CHK_H;
      end
      S_CHK_H: begin
        cmd.walk_chk = 1'b1;
        if (sts.root_hit) begin
          cmd.save_h = 1'b1;
          cmd.find_t_init = 1'b1;
          state_nxt = S_RD_T;
        end else begin
          state_nxt = S_RD_H;
        end
      end
      S_RD_T: begin
        cmd.walk_rd = 1'b1;
        state_nxt = S_CHK_T;
      end
      S_CHK_T: begin
        cmd.walk_chk = 1'b1;
        state_nxt = sts.root_hit ? S_LINK : S_RD_T;
      end
      S_LINK: begin
        cmd.link = 1'b1;
        cmd.scan_init = 1'b1;
        state_nxt = sts.last_pass ? S_SUMM : S_SCAN;
      end
      S_SUMM: begin
        cmd.summary = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: hw/rtl/msf_datapath.sv
// Edge store, ordering scan, union-find parent store and result register.
// Depends on msf_pkg; controlled by msf_ctrl.
module msf_datapath #(
  parameter int NODE_SLOTS = 64,
  parameter int EDGE_SLOTS = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  msf_pkg::in_t  in_data,
  input  msf_pkg::cmd_t cmd,
  output msf_pkg::sts_t sts,
  output logic          out_valid,
  output msf_pkg::out_t out_data
);
  import msf_pkg::*;

  localparam int NW = $clog2(NODE_SLOTS);
  localparam int EW = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;
  localparam int CW = $clog2(EDGE_SLOTS + 1);

  logic [31:0] cost_mem  [EDGE_SLOTS];
  logic [11:0] ends_mem  [EDGE_SLOTS];
  logic [14:0] ident_mem [EDGE_SLOTS];
  logic [NW-1:0] parent_mem [NODE_SLOTS];

  logic [CW-1:0] cnt_r, scan_idx_r, passes_r;
  logic          ovf_r, rd_v_r, best_found_r, have_last_r, out_valid_r;
  logic [NW-1:0] clr_idx_r, node_r, par_q_r, root_h_r;
  logic [5:0]    tree_cnt_r;
  logic [31:0]   rd_cost_r, best_key_r, last_key_r;
  logic [11:0]   rd_ends_r, best_ends_r;
  logic [14:0]   rd_ident_r, best_ident_r;
  logic [EW-1:0] rd_idx_r, best_idx_r, last_idx_r;
  out_t          out_r;

  logic          qualify, room, issue, gt_last, take, joins, par_we;
  logic [31:0]   cand_key;
  logic [NW-1:0] par_wa, par_wd;

  assign qualify = (in_data.edge_ident != 16'sd0) && !in_data.edge_ident[15] &&
                   ({26'd0, in_data.head_node} < 32'(NODE_SLOTS)) &&
                   ({26'd0, in_data.tail_node} < 32'(NODE_SLOTS));
  assign room    = (cnt_r < CW'(EDGE_SLOTS));
  assign issue   = cmd.scan && (scan_idx_r < cnt_r);

  assign cand_key = {~rd_cost_r[31], rd_cost_r[30:0]};
  assign gt_last  = !have_last_r || ({cand_key, rd_idx_r} > {last_key_r, last_idx_r});
  assign take     = rd_v_r && gt_last && (!best_found_r || (cand_key < best_key_r));

  assign joins  = (root_h_r != node_r) && (tree_cnt_r != 6'(TreeMax));
  assign par_we = cmd.clr || (cmd.link && joins);
  assign par_wa = cmd.clr ? clr_idx_r : root_h_r;
  assign par_wd = cmd.clr ? clr_idx_r : node_r;

  always_ff @(posedge clk) begin
    if (cmd.load && qualify && room) begin
      cost_mem[cnt_r[EW-1:0]]  <= in_data.edge_cost;
      ends_mem[cnt_r[EW-1:0]]  <= {in_data.tail_node, in_data.head_node};
      ident_mem[cnt_r[EW-1:0]] <= in_data.edge_ident[14:0];
    end
    if (issue) begin
      rd_cost_r  <= cost_mem[scan_idx_r[EW-1:0]];
      rd_ends_r  <= ends_mem[scan_idx_r[EW-1:0]];
      rd_ident_r <= ident_mem[scan_idx_r[EW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (par_we) parent_mem[par_wa] <= par_wd;
    if (cmd.walk_rd) par_q_r <= parent_mem[node_r];
  end

  always_ff @(posedge clk) begin
    if (issue) rd_idx_r <= scan_idx_r[EW-1:0];
    if (take) begin
      best_key_r   <= cand_key;
      best_idx_r   <= rd_idx_r;
      best_ends_r  <= rd_ends_r;
      best_ident_r <= rd_ident_r;
    end
    if (cmd.find_h_init)                   node_r <= NW'(best_ends_r[5:0]);
    else if (cmd.find_t_init)              node_r <= NW'(best_ends_r[11:6]);
    else if (cmd.walk_chk && !sts.root_hit) node_r <= par_q_r;
    if (cmd.save_h) root_h_r <= node_r;
    if (cmd.link) begin
      last_key_r <= best_key_r;
      last_idx_r <= best_idx_r;
    end
    if (cmd.link) begin
      out_r.tree_edge_id    <= best_ident_r;
      out_r.is_summary      <= 1'b0;
      out_r.tree_edge_count <= tree_cnt_r + 6'd1;
      out_r.store_overflow  <= ovf_r;
      out_r.run_end         <= 1'b0;
    end else if (cmd.summary) begin
      out_r.tree_edge_id    <= '0;
      out_r.is_summary      <= 1'b1;
      out_r.tree_edge_count <= tree_cnt_r;
      out_r.store_overflow  <= ovf_r;
      out_r.run_end         <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      ovf_r        <= 1'b0;
      scan_idx_r   <= '0;
      passes_r     <= '0;
      rd_v_r       <= 1'b0;
      best_found_r <= 1'b0;
      have_last_r  <= 1'b0;
      clr_idx_r    <= '0;
      tree_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= (cmd.link && joins) || cmd.summary;
      if (cmd.load && qualify) begin
        if (room) cnt_r <= cnt_r + CW'(1);
        else      ovf_r <= 1'b1;
      end
      if (cmd.job_init) begin
        clr_idx_r   <= '0;
        passes_r    <= '0;
        tree_cnt_r  <= '0;
        have_last_r <= 1'b0;
      end
      if (cmd.clr) clr_idx_r <= clr_idx_r + NW'(1);
      if (cmd.scan_init) begin
        scan_idx_r   <= '0;
        rd_v_r       <= 1'b0;
        best_found_r <= 1'b0;
      end else begin
        rd_v_r <= issue;
        if (issue) scan_idx_r <= scan_idx_r + CW'(1);
        if (take)  best_found_r <= 1'b1;
      end
      if (cmd.link) begin
        have_last_r <= 1'b1;
        passes_r    <= passes_r + CW'(1);
        if (joins) tree_cnt_r <= tree_cnt_r + 6'd1;
      end
      if (cmd.summary) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end
    end
  end

  assign sts.clr_last  = (clr_idx_r == NW'(NODE_SLOTS - 1));
  assign sts.n_zero    = (cnt_r == '0);
  assign sts.scan_done = (scan_idx_r == cnt_r) && !rd_v_r;
  assign sts.root_hit  = (par_q_r == node_r);
  assign sts.last_pass = (CW'(passes_r + CW'(1)) == cnt_r);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: hw/rtl/minimum_spanning_forest_core.sv
// Top level of the minimum spanning forest core.
// Depends on msf_pkg, msf_ctrl and msf_datapath.
//
// Edges enter on in_data; a transaction completes when start is high and busy
// is low. While no edge marked final_edge has arrived, busy stays low and one
// edge is taken every cycle. An edge with a non-positive id or an end outside
// the node range is discarded; one that finds the store full is dropped and
// raises store_overflow for the job.
// The final edge starts the job and busy rises. The parent store is first set
// to identity. Each stored edge is then picked in ascending cost order (ties
// in load order) by a scan of the edge store, followed by two root walks that
// read and check the parent of each node visited (at least one each) and one
// link step.
// Each tree edge appears on out_data for one cycle with out_valid high; the
// summary with run_end set comes last, with busy low.
// The receiver cannot hold results off. After reset the store is empty and the
// block is idle.
module minimum_spanning_forest_core #(
  parameter int NODE_SLOTS = 64,
  parameter int EDGE_SLOTS = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  msf_pkg::in_t  in_data,
  output logic          out_valid,
  output msf_pkg::out_t out_data
);
  import msf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  msf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_final (in_data.final_edge),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  msf_datapath #(
    .NODE_SLOTS (NODE_SLOTS),
    .EDGE_SLOTS (EDGE_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: hw/rtl/msf_checker.sv
// Port-level assertions for the minimum spanning forest core and its bind.
// Depends on msf_pkg and minimum_spanning_forest_core_macros.svh.
`include "minimum_spanning_forest_core_macros.svh"
module msf_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input msf_pkg::in_t  in_data,
  input logic          out_valid,
  input msf_pkg::out_t out_data
);
  import msf_pkg::*;

  `MSF_ASSERT_SAME(a_end_is_summary, out_valid && out_data.run_end, out_data.is_summary)
  `MSF_ASSERT_SAME(a_tree_while_busy, out_valid && !out_data.is_summary, busy)
  `MSF_ASSERT_SAME(a_summary_idle, out_valid && out_data.is_summary, !busy)
  `MSF_ASSERT_NEXT(a_load_stays_idle, start && !busy && !in_data.final_edge, !busy)
  `MSF_ASSERT_SAME(a_summary_no_id, out_valid && out_data.is_summary,
                   out_data.tree_edge_id == 15'd0)

endmodule

bind minimum_spanning_forest_core msf_checker u_msf_checker (.*);

// File: tb/minimum_spanning_forest_core_tb.sv
// Self-checking testbench for the minimum spanning forest core.
// Depends on msf_pkg and minimum_spanning_forest_core; predicts tree edges in-line.
`timescale 1ns / 100ps
module minimum_spanning_forest_core_tb;
  import msf_pkg::*;

  localparam int NodeCount = 64;
  localparam int EdgeCap   = 256;
  localparam int StallLimit = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;

  minimum_spanning_forest_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  out_t tree_expected[$];
  int   errors = 0;
  bit   gaps_on = 1'b1;
  int   quiet_cycles = 0;

  logic signed [31:0] held_cost[EdgeCap];
  logic [5:0]         held_head[EdgeCap];
  logic [5:0]         held_tail[EdgeCap];
  logic [14:0]        held_id[EdgeCap];
  int                 held_count = 0;
  bit                 held_dropped = 1'b0;
  int                 forest_link[NodeCount];

  function automatic int forest_root(int v);
    int r;
    int nxt;
    r = v;
    while (forest_link[r] != r) r = forest_link[r];
    while (forest_link[v] != v) begin
      nxt = forest_link[v];
      forest_link[v] = r;
      v = nxt;
    end
    return r;
  endfunction

  function automatic void predict_forest(in_t it);
    int   order[EdgeCap];
    int   j;
    int   rh;
    int   rt;
    int   cnt;
    out_t res;
    if (it.edge_ident > 0) begin
      if (held_count < EdgeCap) begin
        held_cost[held_count] = it.edge_cost;
        held_head[held_count] = it.head_node;
        held_tail[held_count] = it.tail_node;
        held_id[held_count]   = it.edge_ident[14:0];
        held_count++;
      end else begin
        held_dropped = 1'b1;
      end
    end
    if (!it.final_edge) return;
    for (int i = 0; i < held_count; i++) begin
      j = i;
      while (j > 0 && held_cost[order[j-1]] > held_cost[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (int i = 0; i < NodeCount; i++) forest_link[i] = i;
    cnt = 0;
    for (int i = 0; i < held_count; i++) begin
      rh = forest_root(held_head[order[i]]);
      rt = forest_root(held_tail[order[i]]);
      if (rh != rt && cnt < TreeMax) begin
        forest_link[rh] = rt;
        cnt++;
        res = '{tree_edge_id: held_id[order[i]], is_summary: 1'b0,
                tree_edge_count: cnt[5:0], store_overflow: held_dropped, run_end: 1'b0};
        tree_expected.push_back(res);
      end
    end
    res = '{tree_edge_id: '0, is_summary: 1'b1, tree_edge_count: cnt[5:0],
            store_overflow: held_dropped, run_end: 1'b1};
    tree_expected.push_back(res);
    held_count = 0;
    held_dropped = 1'b0;
  endfunction

  task automatic send_edge(input logic [5:0] h, input logic [5:0] t,
                           input logic signed [31:0] c, input logic signed [15:0] id,
                           input logic fin);
    in_t it;
    it = '{head_node: h, tail_node: t, edge_cost: c, edge_ident: id, final_edge: fin};
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    predict_forest(it);
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (tree_expected.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        want = tree_expected.pop_front();
        if (out_data.tree_edge_id !== want.tree_edge_id ||
            out_data.is_summary !== want.is_summary ||
            out_data.tree_edge_count !== want.tree_edge_count ||
            out_data.store_overflow !== want.store_overflow ||
            out_data.run_end !== want.run_end) begin
          $display("%0t: result mismatch, expected %p, actual %p", $time, want, out_data);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= StallLimit) begin
      $display("minimum_spanning_forest_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_directed();
    send_edge(6'd0, 6'd63, 32'sh8000_0000, 16'sd1, 1'b0);
    send_edge(6'd63, 6'd0, 32'sh7fff_ffff, 16'sd32767, 1'b0);
    send_edge(6'd5, 6'd5, -32'sd7, 16'sd20, 1'b0);
    send_edge(6'd1, 6'd2, 32'sd3, 16'sd0, 1'b0);
    send_edge(6'd1, 6'd2, 32'sd3, -16'sd1, 1'b0);
    send_edge(6'd1, 6'd2, 32'sd3, 16'sh8000, 1'b0);
    send_edge(6'd1, 6'd2, 32'sd3, 16'sd30, 1'b0);
    send_edge(6'd2, 6'd1, 32'sd3, 16'sd31, 1'b0);
    send_edge(6'd2, 6'd3, 32'sd3, 16'sd32, 1'b0);
    send_edge(6'd63, 6'd3, 32'sd0, 16'sh2aaa, 1'b0);
    send_edge(6'd0, 6'd63, -32'sd1, 16'sh5555, 1'b1);
    send_edge(6'd9, 6'd10, 32'sd1, 16'sd0, 1'b1);
    send_edge(6'd9, 6'd9, 32'sd1, 16'sd4, 1'b1);
    send_edge(6'd9, 6'd10, 32'sd1, 16'sd5, 1'b0);
    send_edge(6'd10, 6'd9, 32'sd0, 16'sd6, 1'b1);
  endtask

  task automatic test_full_tree();
    for (int i = 0; i < 63; i++)
      send_edge(i[5:0], 6'(i + 1), $urandom_range(0, 50), 16'(i + 100), 1'b0);
    send_edge(6'd0, 6'd63, 32'sd1, 16'sd7, 1'b1);
  endtask

  task automatic test_overflow();
    for (int i = 0; i < 259; i++)
      send_edge(6'($urandom_range(0, 20)), 6'($urandom_range(0, 20)),
                $signed(32'($urandom_range(0, 8)) - 32'sd4), 16'(i + 1), i == 258);
  endtask

  task automatic random_job(input int n);
    logic [5:0]         h;
    logic [5:0]         t;
    logic signed [31:0] c;
    logic signed [15:0] id;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        h = 6'($urandom);
        t = 6'($urandom);
      end else begin
        h = 6'($urandom_range(0, 11));
        t = 6'($urandom_range(0, 11));
      end
      c  = ($urandom_range(0, 1) == 0) ? $urandom : $signed(32'($urandom_range(0, 6)) - 32'sd3);
      id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 32767));
      send_edge(h, t, c, id, i == n - 1);
    end
  endtask

  task automatic test_random();
    for (int j = 0; j < 8; j++) random_job($urandom_range(1, 12));
  endtask

  task automatic test_no_gaps();
    gaps_on = 1'b0;
    for (int j = 0; j < 6; j++) random_job($urandom_range(1, 10));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_tree();
    test_overflow();
    test_random();
    test_no_gaps();
    start <= 1'b0;
    while (tree_expected.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("minimum_spanning_forest_core regression: pass");
    end else begin
      $display("minimum_spanning_forest_core regression: fail");
    end
    $finish;
  end

endmodule
